FILE: rtl/npra_pkg.sv
// Shared types and codes for the neighbor pair resource arbiter.
// Used by npra_ctrl, npra_dp and the top level; no dependencies.
package npra_pkg;

  localparam int SEATS_DEF = 5;
  localparam int REQ_W     = 2;
  localparam int SEAT_W    = 4;

  localparam logic [REQ_W-1:0] REQ_HUNGRY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DONE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TOGGLE = 2'd2;

  typedef logic [2:0] op_t;
  localparam op_t OP_NONE  = 3'd0;
  localparam op_t OP_PRIM  = 3'd1;
  localparam op_t OP_PREV  = 3'd2;
  localparam op_t OP_NEXT  = 3'd3;
  localparam op_t OP_SCAN  = 3'd4;
  localparam op_t OP_FINAL = 3'd5;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic stall;
    logic go_neigh;
    logic go_scan;
    logic scan_last;
  } sts_t;

endpackage

FILE: rtl/npra_dp.sv
// Datapath: fork/waiting/pause state, grant evaluation, pending grant and output register.
// Depends on npra_pkg; driven by npra_ctrl.
module npra_dp #(
  parameter int SEATS = npra_pkg::SEATS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [npra_pkg::REQ_W-1:0]  in_req_type,
  input  logic [npra_pkg::SEAT_W-1:0] in_seat,
  input  npra_pkg::cmd_t              cmd,
  output npra_pkg::sts_t              sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_granted,
  output logic [npra_pkg::SEAT_W-1:0] out_grant_seat,
  output logic                        out_error,
  output logic                        out_is_paused,
  output logic                        out_last
);
  import npra_pkg::*;

  localparam int IW = (SEATS > 1) ? $clog2(SEATS) : 1;
  typedef logic [IW-1:0] idx_t;

  function automatic idx_t nxt_seat(input idx_t s);
    return (s == idx_t'(SEATS - 1)) ? '0 : s + idx_t'(1);
  endfunction

  function automatic idx_t prv_seat(input idx_t s);
    return (s == '0) ? idx_t'(SEATS - 1) : s - idx_t'(1);
  endfunction

  logic [SEATS-1:0]  fork_r, fork_nxt;
  logic [SEATS-1:0]  wait_r, wait_nxt;
  logic              pause_r, pause_nxt;
  logic [REQ_W-1:0]  type_r;
  logic [SEAT_W-1:0] seat_r;
  logic              err_r, err_nxt;
  idx_t              idx_r, idx_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  idx_t              pend_seat_r, pend_seat_nxt;

  logic              out_vld_r;
  logic              out_grant_r;
  logic [SEAT_W-1:0] out_seat_r;
  logic              out_err_r;
  logic              out_pause_r;
  logic              out_last_r;

  logic              seat_ok;
  idx_t              n;
  idx_t              g;
  logic              hit;
  logic              push;
  logic              push_grant;
  idx_t              push_seat;
  logic              push_last;
  logic              push_err;
  logic              out_free;
  logic              stall;
  logic              adv;

  assign seat_ok  = ({1'b0, seat_r} < 5'(SEATS));
  assign n        = seat_r[IW-1:0];
  assign out_free = !out_vld_r || out_ready;

  always_comb begin
    fork_nxt      = fork_r;
    wait_nxt      = wait_r;
    pause_nxt     = pause_r;
    err_nxt       = err_r;
    idx_nxt       = idx_r;
    pend_vld_nxt  = pend_vld_r;
    pend_seat_nxt = pend_seat_r;
    g             = n;
    hit           = 1'b0;
    push          = 1'b0;
    push_grant    = 1'b0;
    push_seat     = '0;
    push_last     = 1'b0;
    push_err      = 1'b0;
    case (cmd.op)
      OP_PRIM: begin
        if (type_r == REQ_HUNGRY) begin
          if (!seat_ok || wait_r[n]) begin
            err_nxt = 1'b1;
          end else if (!pause_r && !fork_r[n] && !fork_r[nxt_seat(n)]) begin
            hit = 1'b1;
          end else begin
            wait_nxt[n] = 1'b1;
          end
        end else if (type_r == REQ_DONE) begin
          if (!seat_ok) begin
            err_nxt = 1'b1;
          end else begin
            fork_nxt[n]           = 1'b0;
            fork_nxt[nxt_seat(n)] = 1'b0;
          end
        end else if (type_r == REQ_TOGGLE) begin
          pause_nxt = !pause_r;
        end
      end
      OP_PREV: begin
        g   = prv_seat(n);
        hit = wait_r[g] && !fork_r[g];
      end
      OP_NEXT: begin
        g   = nxt_seat(n);
        hit = wait_r[g] && !fork_r[nxt_seat(g)];
      end
      OP_SCAN: begin
        g       = idx_r;
        hit     = wait_r[g] && !fork_r[g] && !fork_r[nxt_seat(g)];
        idx_nxt = idx_r + idx_t'(1);
      end
      OP_FINAL: begin
        push         = 1'b1;
        push_grant   = pend_vld_r;
        push_seat    = pend_vld_r ? pend_seat_r : '0;
        push_last    = 1'b1;
        push_err     = err_r;
        pend_vld_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    if (hit) begin
      fork_nxt[g]           = 1'b1;
      fork_nxt[nxt_seat(g)] = 1'b1;
      wait_nxt[g]           = 1'b0;
      // a newer grant exists, so the held one is not last
      if (pend_vld_r) begin
        push       = 1'b1;
        push_grant = 1'b1;
        push_seat  = pend_seat_r;
      end
      pend_vld_nxt  = 1'b1;
      pend_seat_nxt = g;
    end
  end

  assign stall = push && !out_free;
  assign adv   = (cmd.op != OP_NONE) && !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fork_r     <= '0;
      wait_r     <= '0;
      pause_r    <= 1'b0;
      err_r      <= 1'b0;
      idx_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        err_r      <= 1'b0;
        idx_r      <= '0;
        pend_vld_r <= 1'b0;
      end else if (adv) begin
        fork_r     <= fork_nxt;
        wait_r     <= wait_nxt;
        pause_r    <= pause_nxt;
        err_r      <= err_nxt;
        idx_r      <= idx_nxt;
        pend_vld_r <= pend_vld_nxt;
      end
      if (adv && push) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= in_req_type;
      seat_r <= in_seat;
    end
    if (adv) begin
      pend_seat_r <= pend_seat_nxt;
    end
    if (adv && push) begin
      out_grant_r <= push_grant;
      out_seat_r  <= SEAT_W'(push_seat);
      out_err_r   <= push_err;
      out_pause_r <= pause_nxt;
      out_last_r  <= push_last;
    end
  end

  assign sts.stall     = stall;
  assign sts.go_neigh  = (type_r == REQ_DONE) && seat_ok && !pause_r;
  assign sts.go_scan   = (type_r == REQ_TOGGLE) && pause_r;
  assign sts.scan_last = (idx_r == idx_t'(SEATS - 1));

  assign out_valid      = out_vld_r;
  assign out_granted    = out_grant_r;
  assign out_grant_seat = out_seat_r;
  assign out_error      = out_err_r;
  assign out_is_paused  = out_pause_r;
  assign out_last       = out_last_r;

endmodule

FILE: rtl/npra_ctrl.sv
// Controller: sequences the primary action, neighbor offers, resume scan and final result.
// Depends on npra_pkg; drives npra_dp.
module npra_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  npra_pkg::sts_t sts,
  output npra_pkg::cmd_t cmd
);
  import npra_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIM  = 3'd1;
  localparam logic [2:0] S_PREV  = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_PRIM;
      end
      S_PRIM: begin
        cmd.op = OP_PRIM;
        if (!sts.stall) begin
          if (sts.go_neigh)     state_nxt = S_PREV;
          else if (sts.go_scan) state_nxt = S_SCAN;
          else                  state_nxt = S_FINAL;
        end
      end
      S_PREV: begin
        cmd.op = OP_PREV;
        if (!sts.stall) state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.op = OP_NEXT;
        if (!sts.stall) state_nxt = S_FINAL;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (!sts.stall && sts.scan_last) state_nxt = S_FINAL;
      end
      S_FINAL: begin
        cmd.op = OP_FINAL;
        if (!sts.stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/neighbor_pair_resource_arbiter.sv
// Top level of the ring fork arbiter: controller plus datapath.
// Depends on npra_pkg, npra_ctrl and npra_dp.
//
//  channel  | direction | ports
//  ---------+-----------+-----------------------------------------------------------
//  in       | input     | in_valid, in_ready, in_req_type, in_seat
//  out      | output    | out_valid, out_ready, out_granted, out_grant_seat,
//           |           | out_error, out_is_paused, out_last
//
// One transaction at a time: hungry, pause, unused codes, errors and a done while paused run
// the primary and final steps; a done while serving adds the previous and next neighbor offers,
// and a resume adds a scan over every seat of the ring, one step per cycle unless stalled.
// Each result waits for the single output register; a stalled out side holds the sequencer.
// in_ready is high only between transactions. Synchronous active-low reset frees all forks,
// clears all waiting seats and leaves the arbiter serving.
module neighbor_pair_resource_arbiter #(
  parameter int SEATS = npra_pkg::SEATS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [npra_pkg::REQ_W-1:0]  in_req_type,
  input  logic [npra_pkg::SEAT_W-1:0] in_seat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_granted,
  output logic [npra_pkg::SEAT_W-1:0] out_grant_seat,
  output logic                        out_error,
  output logic                        out_is_paused,
  output logic                        out_last
);
  import npra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  npra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  npra_dp #(
    .SEATS (SEATS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_req_type    (in_req_type),
    .in_seat        (in_seat),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_granted    (out_granted),
    .out_grant_seat (out_grant_seat),
    .out_error      (out_error),
    .out_is_paused  (out_is_paused),
    .out_last       (out_last)
  );

  a_nogrant_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_granted |-> out_last)
    else $error("no-grant result not flagged last");

  a_err_nogrant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_granted)
    else $error("ignored request produced a grant");

  a_seat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> ({1'b0, out_grant_seat} < 5'(SEATS)))
    else $error("grant to seat outside the ring");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("new transaction taken while busy");

endmodule
